### sv/bzfb_pkg.sv
// ----------------------------------------------------------------------------
// bzfb_pkg
// Shared types and constants for the bilinear zoom / feather blend pipeline.
// ----------------------------------------------------------------------------
package bzfb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int NUM_W    = SAMPLE_W + WEIGHT_W;
  // quotient never exceeds the larger blended sample, so one bit per stage
  localparam int DIV_STAGES = SAMPLE_W;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [FRAC_W-1:0]   frac_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [NUM_W-1:0]    num_t;

  typedef struct packed {
    sample_t top_left;
    sample_t top_right;
    sample_t bottom_left;
    sample_t bottom_right;
    frac_t   frac_x;
    frac_t   frac_y;
    sample_t dest_prev;
    weight_t weight_total;
    weight_t weight_current;
  } in_item_t;

  // interpolated sample plus the blend weights
  typedef struct packed {
    sample_t fresh;
    sample_t dest_prev;
    weight_t total;
    weight_t cur;
    weight_t rest;
  } interp_item_t;

  // blend numerator ready for division
  typedef struct packed {
    num_t    num;
    weight_t total;
    sample_t fresh;
  } blend_item_t;

endpackage

### sv/bzfb_if.sv
// ----------------------------------------------------------------------------
// bzfb_if
// Valid/ready channels for the input item and the blended result.
// ----------------------------------------------------------------------------
interface bzfb_in_if;
  logic                   valid;
  logic                   ready;
  logic [15:0]            top_left;
  logic [15:0]            top_right;
  logic [15:0]            bottom_left;
  logic [15:0]            bottom_right;
  logic [7:0]             frac_x;
  logic [7:0]             frac_y;
  logic [15:0]            dest_prev;
  logic [15:0]            weight_total;
  logic [15:0]            weight_current;

  modport source (
    output valid, top_left, top_right, bottom_left, bottom_right,
           frac_x, frac_y, dest_prev, weight_total, weight_current,
    input  ready
  );
  modport sink (
    input  valid, top_left, top_right, bottom_left, bottom_right,
           frac_x, frac_y, dest_prev, weight_total, weight_current,
    output ready
  );
endinterface

interface bzfb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] blended;

  modport source (output valid, blended, input ready);
  modport sink   (input valid, blended, output ready);
endinterface

### sv/bilinear_zoom_feather_blend.sv
// ----------------------------------------------------------------------------
// bilinear_zoom_feather_blend
// Bilinear sample of four neighbours, feather-blended into the destination.
// ----------------------------------------------------------------------------
// Takes one destination pixel per clock unless a held output has filled the
// pipeline, and returns one blended sample per transaction.
// Interpolation takes two stages, the weighted numerator two more, and the
// division by the total weight 16 stages at one quotient bit each; that
// divider sets the depth. Every stage stalls on its own, so a held output
// only stops new transactions once all bubbles in the pipeline are filled.
module bilinear_zoom_feather_blend (
  input  logic       clk,
  input  logic       rst_n,
  bzfb_in_if.sink    in_ch,
  bzfb_out_if.source out_ch
);
  import bzfb_pkg::*;

  in_item_t     in_item;
  interp_item_t interp_item;
  blend_item_t  blend_item;
  logic         interp_valid, interp_ready;
  logic         blend_valid, blend_ready;

  always_comb begin
    in_item.top_left       = in_ch.top_left;
    in_item.top_right      = in_ch.top_right;
    in_item.bottom_left    = in_ch.bottom_left;
    in_item.bottom_right   = in_ch.bottom_right;
    in_item.frac_x         = in_ch.frac_x;
    in_item.frac_y         = in_ch.frac_y;
    in_item.dest_prev      = in_ch.dest_prev;
    in_item.weight_total   = in_ch.weight_total;
    in_item.weight_current = in_ch.weight_current;
  end

  bzfb_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (interp_valid),
    .out_ready (interp_ready),
    .out_item  (interp_item)
  );

  bzfb_blend_mul u_blend_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (interp_valid),
    .in_ready  (interp_ready),
    .in_item   (interp_item),
    .out_valid (blend_valid),
    .out_ready (blend_ready),
    .out_item  (blend_item)
  );

  bzfb_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (blend_valid),
    .in_ready    (blend_ready),
    .in_item     (blend_item),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_blended (out_ch.blended)
  );

endmodule

### sv/bzfb_interp.sv
// ----------------------------------------------------------------------------
// bzfb_interp
// Two-stage bilinear interpolation: horizontal pair, then vertical.
// ----------------------------------------------------------------------------
module bzfb_interp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bzfb_pkg::in_item_t      in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bzfb_pkg::interp_item_t  out_item
);
  import bzfb_pkg::*;

  typedef struct packed {
    sample_t top;
    sample_t bot;
    frac_t   frac_y;
    sample_t dest_prev;
    weight_t total;
    weight_t cur;
    weight_t rest;
  } horiz_t;

  // a*(256-f) + b*f == a*256 + (b-a)*f, one multiplier per lerp
  function automatic sample_t lerp8(input sample_t a, input sample_t b, input frac_t f);
    logic signed [SAMPLE_W:0]            diff;
    logic signed [SAMPLE_W+FRAC_W+1:0]   acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    acc  = $signed({2'b00, a, {FRAC_W{1'b0}}}) + diff * $signed({1'b0, f});
    return acc[SAMPLE_W+FRAC_W-1:FRAC_W];
  endfunction

  logic         v1_r, v2_r;
  logic         en1, en2;
  horiz_t       s1_r, s1_nxt;
  interp_item_t s2_r, s2_nxt;
  weight_t      cur_clamp;

  always_comb begin
    en2      = !v2_r || out_ready;
    en1      = !v1_r || en2;
    in_ready = en1;
  end

  always_comb begin
    cur_clamp = (in_item.weight_current > in_item.weight_total) ?
                in_item.weight_total : in_item.weight_current;
    s1_nxt.top       = lerp8(in_item.top_left, in_item.top_right, in_item.frac_x);
    s1_nxt.bot       = lerp8(in_item.bottom_left, in_item.bottom_right, in_item.frac_x);
    s1_nxt.frac_y    = in_item.frac_y;
    s1_nxt.dest_prev = in_item.dest_prev;
    s1_nxt.total     = in_item.weight_total;
    s1_nxt.cur       = cur_clamp;
    s1_nxt.rest      = in_item.weight_total - cur_clamp;
  end

  always_comb begin
    s2_nxt.fresh     = lerp8(s1_r.top, s1_r.bot, s1_r.frac_y);
    s2_nxt.dest_prev = s1_r.dest_prev;
    s2_nxt.total     = s1_r.total;
    s2_nxt.cur       = s1_r.cur;
    s2_nxt.rest      = s1_r.rest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
  end

  assign out_valid = v2_r;
  assign out_item  = s2_r;

endmodule

### sv/bzfb_blend_mul.sv
// ----------------------------------------------------------------------------
// bzfb_blend_mul
// Blend numerator: two weight products, then their sum.
// ----------------------------------------------------------------------------
module bzfb_blend_mul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  bzfb_pkg::interp_item_t  in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bzfb_pkg::blend_item_t   out_item
);
  import bzfb_pkg::*;

  typedef struct packed {
    num_t    prod_prev;
    num_t    prod_fresh;
    weight_t total;
    sample_t fresh;
  } prod_t;

  logic        v1_r, v2_r;
  logic        en1, en2;
  prod_t       s1_r, s1_nxt;
  blend_item_t s2_r, s2_nxt;

  always_comb begin
    en2      = !v2_r || out_ready;
    en1      = !v1_r || en2;
    in_ready = en1;
  end

  always_comb begin
    s1_nxt.prod_prev  = num_t'(in_item.dest_prev) * num_t'(in_item.rest);
    s1_nxt.prod_fresh = num_t'(in_item.fresh) * num_t'(in_item.cur);
    s1_nxt.total      = in_item.total;
    s1_nxt.fresh      = in_item.fresh;
  end

  // sum stays below 65536*total, so it fits the numerator width
  always_comb begin
    s2_nxt.num   = s1_r.prod_prev + s1_r.prod_fresh;
    s2_nxt.total = s1_r.total;
    s2_nxt.fresh = s1_r.fresh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
  end

  assign out_valid = v2_r;
  assign out_item  = s2_r;

endmodule

### sv/bzfb_div.sv
// ----------------------------------------------------------------------------
// bzfb_div
// Pipelined restoring divider, one quotient bit per stage, with the
// zero-total bypass applied at the output.
// ----------------------------------------------------------------------------
module bzfb_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bzfb_pkg::blend_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bzfb_pkg::sample_t      out_blended
);
  import bzfb_pkg::*;

  typedef struct packed {
    weight_t rem;
    num_t    shq;     // numerator bits still to come, quotient shifted in below
    weight_t divisor;
    sample_t fresh;
  } div_stage_t;

  logic       v_r  [DIV_STAGES];
  logic       en   [DIV_STAGES];
  div_stage_t st_r [DIV_STAGES];
  div_stage_t st_nxt [DIV_STAGES];

  function automatic div_stage_t div_step(input div_stage_t s);
    logic [WEIGHT_W:0] trial;
    logic              ge;
    div_stage_t        r;
    trial   = {s.rem, s.shq[NUM_W-1]};
    ge      = (trial >= {1'b0, s.divisor});
    r       = s;
    r.rem   = ge ? WEIGHT_W'(trial - {1'b0, s.divisor}) : trial[WEIGHT_W-1:0];
    r.shq   = {s.shq[NUM_W-2:0], ge};
    return r;
  endfunction

  // ready chain runs back from the output register
  always_comb begin
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      if (k == DIV_STAGES - 1) en[k] = !v_r[k] || out_ready;
      else                     en[k] = !v_r[k] || en[k+1];
    end
    in_ready = en[0];
  end

  // high half of the numerator is already below the divisor
  always_comb begin
    div_stage_t first;
    first.rem     = in_item.num[NUM_W-1:NUM_W-WEIGHT_W];
    first.shq     = {in_item.num[NUM_W-WEIGHT_W-1:0], {WEIGHT_W{1'b0}}};
    first.divisor = in_item.total;
    first.fresh   = in_item.fresh;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) st_nxt[k] = div_step(first);
      else        st_nxt[k] = div_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) v_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (en[k]) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) st_r[k] <= st_nxt[k];
    end
  end

  assign out_valid   = v_r[DIV_STAGES-1];
  assign out_blended = (st_r[DIV_STAGES-1].divisor == '0) ?
                       st_r[DIV_STAGES-1].fresh :
                       st_r[DIV_STAGES-1].shq[SAMPLE_W-1:0];

endmodule

### sv/bzfb_checker.sv
// ----------------------------------------------------------------------------
// bzfb_checker
// Port-level checks on the blend pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bzfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_blended
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty output stage means every stage can load
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  // a draining output never back-pressures the input
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blended))
    else $error("result dropped or changed while stalled");

endmodule

bind bilinear_zoom_feather_blend bzfb_checker u_bzfb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_blended (out_ch.blended)
);
